@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the flight phase detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FPD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FPD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/fpd_pkg.sv @@
// Package: types, codes and reset values of the flight phase detector.
`default_nettype none
package fpd_pkg;

  localparam int unsigned SqW = 31;

  typedef enum logic [2:0] {
    STG_IDLE    = 3'd0,
    STG_LAUNCH  = 3'd1,
    STG_APOGEE  = 3'd2,
    STG_DESCENT = 3'd3,
    STG_LANDED  = 3'd4
  } stage_t;

  typedef enum logic [1:0] {
    BUZ_SLOW  = 2'd0,
    BUZ_QUICK = 2'd1,
    BUZ_SWEEP = 2'd2
  } buzz_t;

  typedef enum logic [1:0] {
    CFG_LAUNCH_LIMIT = 2'd0,
    CFG_APOGEE_LIMIT = 2'd1,
    CFG_LANDING_BAND = 2'd2,
    CFG_COUNT_LIMIT  = 2'd3
  } cfg_idx_t;

  localparam logic [14:0]        LaunchLimitRst = 15'd5120;
  localparam logic signed [15:0] ApogeeLimitRst = -16'sd102;
  localparam logic [14:0]        LandingBandRst = 15'd20;
  localparam logic [15:0]        CountLimitRst  = 16'd10;
  localparam logic [15:0]        CountMax       = 16'hFFFF;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] pressure_rate;
  } in_t;

  typedef struct packed {
    logic [2:0] flight_stage;
    logic [1:0] buzzer_mode;
    logic       pyro_fire;
    logic       launch_seen;
    logic       apogee_seen;
    logic       landing_seen;
  } out_t;

  typedef struct packed {
    logic [14:0]        launch_limit;
    logic signed [15:0] apogee_limit;
    logic [14:0]        landing_band;
    logic [15:0]        count_limit;
  } cfg_t;

  typedef struct packed {
    logic [SqW-1:0] sq_x;
    logic [SqW-1:0] sq_y;
    logic [SqW-1:0] sq_z;
    logic           y_over;
    logic           apogee_q;
    logic           landing_q;
  } qual_t;

endpackage
`default_nettype wire

@@ rtl/core/fpd_cfg.sv @@
// Configuration register file and the squared launch threshold.
`default_nettype none
module fpd_cfg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [15:0]   cfg_wdata,
  output fpd_pkg::cfg_t      cfg_o,
  output logic [29:0]        lim_sq_o
);

  fpd_pkg::cfg_t cfg_r;
  logic [29:0]   lim_sq_r;
  logic [29:0]   lim_sq_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.launch_limit <= fpd_pkg::LaunchLimitRst;
      cfg_r.apogee_limit <= fpd_pkg::ApogeeLimitRst;
      cfg_r.landing_band <= fpd_pkg::LandingBandRst;
      cfg_r.count_limit  <= fpd_pkg::CountLimitRst;
    end else if (cfg_we) begin
      case (fpd_pkg::cfg_idx_t'(cfg_index))
        fpd_pkg::CFG_LAUNCH_LIMIT: cfg_r.launch_limit <= cfg_wdata[14:0];
        fpd_pkg::CFG_APOGEE_LIMIT: cfg_r.apogee_limit <= $signed(cfg_wdata);
        fpd_pkg::CFG_LANDING_BAND: cfg_r.landing_band <= cfg_wdata[14:0];
        fpd_pkg::CFG_COUNT_LIMIT:  cfg_r.count_limit  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign lim_sq_nxt = cfg_r.launch_limit * cfg_r.launch_limit;

  always_ff @(posedge clk) begin
    lim_sq_r <= lim_sq_nxt;
  end

  assign cfg_o    = cfg_r;
  assign lim_sq_o = lim_sq_r;

endmodule
`default_nettype wire

@@ rtl/core/fpd_qualify.sv @@
// Input register, axis squares and rate compares, registered per sample.
`default_nettype none
module fpd_qualify (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire fpd_pkg::in_t   in_data,
  input  wire fpd_pkg::cfg_t  cfg_i,
  output logic                q_valid,
  input  wire logic           q_ready,
  output fpd_pkg::qual_t      q_data
);

  logic           v1_r;
  fpd_pkg::in_t   in_r;
  logic           v2_r;
  fpd_pkg::qual_t q_r;
  fpd_pkg::qual_t q_nxt;
  logic           load1;
  logic           load2;

  logic signed [31:0] sqx_full;
  logic signed [31:0] sqy_full;
  logic signed [31:0] sqz_full;
  logic signed [16:0] rate_ext;
  logic signed [16:0] band_pos;
  logic signed [16:0] band_neg;

  assign load2    = !v2_r || q_ready;
  assign load1    = !v1_r || load2;
  assign in_stall = !load1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (load1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load1 && in_valid) begin
      in_r <= in_data;
    end
  end

  assign sqx_full = $signed(in_r.accel_x) * $signed(in_r.accel_x);
  assign sqy_full = $signed(in_r.accel_y) * $signed(in_r.accel_y);
  assign sqz_full = $signed(in_r.accel_z) * $signed(in_r.accel_z);
  assign rate_ext = {in_r.pressure_rate[15], in_r.pressure_rate};
  assign band_pos = $signed({2'b00, cfg_i.landing_band});
  assign band_neg = -band_pos;

  always_comb begin
    q_nxt.sq_x      = sqx_full[fpd_pkg::SqW-1:0];
    q_nxt.sq_y      = sqy_full[fpd_pkg::SqW-1:0];
    q_nxt.sq_z      = sqz_full[fpd_pkg::SqW-1:0];
    q_nxt.y_over    = $signed(in_r.accel_y) > $signed({1'b0, cfg_i.launch_limit});
    q_nxt.apogee_q  = $signed(in_r.pressure_rate) < cfg_i.apogee_limit;
    q_nxt.landing_q = (rate_ext > band_neg) && (rate_ext < band_pos);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (load2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load2 && v1_r) begin
      q_r <= q_nxt;
    end
  end

  assign q_valid = v2_r;
  assign q_data  = q_r;

endmodule
`default_nettype wire

@@ rtl/core/fpd_stage.sv @@
// Flight stage state machine, shared sample counter and result register.
`default_nettype none
`include "assert_macros.svh"
module fpd_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  output logic                 q_ready,
  input  wire fpd_pkg::qual_t  q_data,
  input  wire fpd_pkg::cfg_t   cfg_i,
  input  wire logic [29:0]     lim_sq_i,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output fpd_pkg::out_t        out_data
);

  fpd_pkg::stage_t stage_r;
  fpd_pkg::stage_t stage_nxt;
  logic [15:0]     count_r;
  logic [15:0]     count_nxt;
  fpd_pkg::buzz_t  buzzer_r;
  fpd_pkg::buzz_t  buzzer_nxt;
  logic            pyro_r;
  logic            pyro_nxt;
  logic            out_valid_r;
  fpd_pkg::out_t   out_data_r;
  fpd_pkg::out_t   out_data_nxt;

  logic [31:0] mag_sq;
  logic        launch_q;
  logic        launch_go;
  logic        in_launch;
  logic [15:0] cnt_a;
  logic        apogee_go;
  logic [15:0] cnt_b;
  logic        in_descent;
  logic [15:0] cnt_c;
  logic        land_go;
  logic        take;

  assign q_ready = !out_valid_r || !out_stall;
  assign take    = q_valid && q_ready;

  assign mag_sq = {1'b0, q_data.sq_x} + {1'b0, q_data.sq_y} + {1'b0, q_data.sq_z};
  assign launch_q = (mag_sq > {2'b00, lim_sq_i}) || q_data.y_over;

  always_comb begin
    launch_go  = (stage_r == fpd_pkg::STG_IDLE) && launch_q;
    in_launch  = (stage_r == fpd_pkg::STG_LAUNCH) || launch_go;
    cnt_a      = (in_launch && q_data.apogee_q && count_r != fpd_pkg::CountMax)
                 ? count_r + 16'd1 : count_r;
    apogee_go  = in_launch && (cnt_a > cfg_i.count_limit);
    cnt_b      = apogee_go ? 16'd0 : cnt_a;
    in_descent = (stage_r == fpd_pkg::STG_DESCENT) || (stage_r == fpd_pkg::STG_APOGEE)
                 || apogee_go;
    cnt_c      = (in_descent && q_data.landing_q && cnt_b != fpd_pkg::CountMax)
                 ? cnt_b + 16'd1 : cnt_b;
    land_go    = in_descent && (cnt_c > cfg_i.count_limit);
  end

  // next state
  always_comb begin
    if (land_go) begin
      stage_nxt = fpd_pkg::STG_LANDED;
    end else if (in_descent) begin
      stage_nxt = fpd_pkg::STG_DESCENT;
    end else if (in_launch) begin
      stage_nxt = fpd_pkg::STG_LAUNCH;
    end else begin
      stage_nxt = stage_r;
    end
  end

  // outputs
  always_comb begin
    count_nxt = land_go ? 16'd0 : cnt_c;
    pyro_nxt  = pyro_r || apogee_go || (stage_r == fpd_pkg::STG_APOGEE);
    if (stage_nxt == fpd_pkg::STG_LANDED) begin
      buzzer_nxt = fpd_pkg::BUZ_SWEEP;
    end else if (apogee_go || launch_go || stage_r == fpd_pkg::STG_APOGEE) begin
      buzzer_nxt = fpd_pkg::BUZ_QUICK;
    end else if (stage_r == fpd_pkg::STG_IDLE) begin
      buzzer_nxt = fpd_pkg::BUZ_SLOW;
    end else begin
      buzzer_nxt = buzzer_r;
    end
    out_data_nxt.flight_stage = stage_nxt;
    out_data_nxt.buzzer_mode  = buzzer_nxt;
    out_data_nxt.pyro_fire    = pyro_nxt;
    out_data_nxt.launch_seen  = launch_go;
    out_data_nxt.apogee_seen  = apogee_go;
    out_data_nxt.landing_seen = land_go;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r     <= fpd_pkg::STG_IDLE;
      count_r     <= 16'd0;
      buzzer_r    <= fpd_pkg::BUZ_SLOW;
      pyro_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_ready) begin
        out_valid_r <= q_valid;
      end
      if (take) begin
        stage_r  <= stage_nxt;
        count_r  <= count_nxt;
        buzzer_r <= buzzer_nxt;
        pyro_r   <= pyro_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `FPD_ASSERT_IMP(a_no_apogee_hold, 1'b1, stage_r != fpd_pkg::STG_APOGEE,
    "stage register holds apogee")
  `FPD_ASSERT_NXT(a_pyro_latched, pyro_r, pyro_r, "pyro latch dropped")
  `FPD_ASSERT_NXT(a_landed_final, stage_r == fpd_pkg::STG_LANDED,
    stage_r == fpd_pkg::STG_LANDED, "left landed stage")
  `FPD_ASSERT_IMP(a_apogee_pyro, out_valid_r && out_data_r.apogee_seen,
    out_data_r.pyro_fire, "apogee beat without pyro")
  `FPD_ASSERT_NXT(a_state_hold, !take, $stable(stage_r) && $stable(count_r),
    "state moved without a beat")

endmodule
`default_nettype wire

@@ rtl/core/flight_phase_detector.sv @@
// Top level: flight phase detector, one sensor sample in, one stage report out.
// A result beat passes the input register, the qualify register and the result register in turn.
// Throughput: one sample per cycle while out_stall is low; the stage update and shared counter are combinational.
// A stalled result holds in the output register while two upstream stages keep filling.
// Reset (synchronous, rst_n low): idle stage, count zero, slow pulse, pyro off,
// registers back to defaults, pipeline empty.
`default_nettype none
module flight_phase_detector (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire fpd_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output fpd_pkg::out_t      out_data,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [15:0]   cfg_wdata
);

  fpd_pkg::cfg_t  cfg;
  logic [29:0]    lim_sq;
  logic           q_valid;
  logic           q_ready;
  fpd_pkg::qual_t q_data;

  fpd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg),
    .lim_sq_o  (lim_sq)
  );

  fpd_qualify u_qualify (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg_i    (cfg),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data)
  );

  fpd_stage u_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .cfg_i     (cfg),
    .lim_sq_i  (lim_sq),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

@@ bench/flight_phase_detector_test.sv @@
// Flight phase detector bench: random and directed samples checked against a stage predictor.
`timescale 1ns / 100ps
module flight_phase_detector_test;

  localparam int StallLimit   = 1000;
  localparam int SettleCycles = 10;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  fpd_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  fpd_pkg::out_t out_data;
  logic          cfg_we    = 1'b0;
  logic [1:0]    cfg_index = '0;
  logic [15:0]   cfg_wdata = '0;

  logic [14:0]        lim_launch = fpd_pkg::LaunchLimitRst;
  logic signed [15:0] lim_apogee = fpd_pkg::ApogeeLimitRst;
  logic [14:0]        lim_band   = fpd_pkg::LandingBandRst;
  logic [15:0]        lim_count  = fpd_pkg::CountLimitRst;
  fpd_pkg::stage_t    fl_stage   = fpd_pkg::STG_IDLE;
  fpd_pkg::buzz_t     fl_buzz    = fpd_pkg::BUZ_SLOW;
  logic               fl_pyro    = 1'b0;
  logic [15:0]        fl_count   = '0;

  fpd_pkg::in_t  samples_to_send[$];
  fpd_pkg::out_t due_reports[$];
  int   samples_queued = 0;
  int   samples_taken  = 0;
  int   mismatches     = 0;
  int   quiet_cycles   = 0;
  int   send_gap       = 0;
  int   stall_gap      = 0;
  logic in_taken       = 1'b0;
  logic no_idle        = 1'b0;

  flight_phase_detector i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic fpd_pkg::out_t advance_flight(fpd_pkg::in_t s);
    longint ax, ay, az, lim, mag_sq;
    int     rate, band, ap;
    fpd_pkg::out_t r;
    ax     = s.accel_x;
    ay     = s.accel_y;
    az     = s.accel_z;
    lim    = lim_launch;
    mag_sq = ax * ax + ay * ay + az * az;
    rate   = s.pressure_rate;
    band   = lim_band;
    ap     = lim_apogee;
    r      = '0;
    if (fl_stage == fpd_pkg::STG_IDLE) begin
      fl_buzz = fpd_pkg::BUZ_SLOW;
      if (mag_sq > lim * lim || ay > lim) begin
        fl_stage      = fpd_pkg::STG_LAUNCH;
        fl_buzz       = fpd_pkg::BUZ_QUICK;
        r.launch_seen = 1'b1;
      end
    end
    if (fl_stage == fpd_pkg::STG_LAUNCH) begin
      if (rate < ap && fl_count != fpd_pkg::CountMax) fl_count++;
      if (fl_count > lim_count) begin
        fl_count      = '0;
        fl_stage      = fpd_pkg::STG_APOGEE;
        fl_pyro       = 1'b1;
        fl_buzz       = fpd_pkg::BUZ_QUICK;
        r.apogee_seen = 1'b1;
      end
    end
    if (fl_stage == fpd_pkg::STG_APOGEE) begin
      fl_pyro  = 1'b1;
      fl_buzz  = fpd_pkg::BUZ_QUICK;
      fl_stage = fpd_pkg::STG_DESCENT;
    end
    if (fl_stage == fpd_pkg::STG_DESCENT) begin
      if (rate > -band && rate < band && fl_count != fpd_pkg::CountMax) fl_count++;
      if (fl_count > lim_count) begin
        fl_count       = '0;
        fl_stage       = fpd_pkg::STG_LANDED;
        r.landing_seen = 1'b1;
      end
    end
    if (fl_stage == fpd_pkg::STG_LANDED) fl_buzz = fpd_pkg::BUZ_SWEEP;
    r.flight_stage = fl_stage;
    r.buzzer_mode  = fl_buzz;
    r.pyro_fire    = fl_pyro;
    return r;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  function automatic logic signed [15:0] pick(int lo, int hi);
    return 16'(lo + int'($urandom_range(hi - lo, 0)));
  endfunction

  function automatic fpd_pkg::in_t make_sample(int ax, int ay, int az, int rate);
    fpd_pkg::in_t s;
    s.accel_x       = 16'(ax);
    s.accel_y       = 16'(ay);
    s.accel_z       = 16'(az);
    s.pressure_rate = 16'(rate);
    return s;
  endfunction

  function automatic fpd_pkg::in_t rand_sample(int span, int lo, int hi);
    return make_sample(pick(-span, span - 1), pick(-span, span - 1), pick(-span, span - 1),
                       pick(lo, hi));
  endfunction

  function automatic void queue_sample(fpd_pkg::in_t s);
    samples_to_send.push_back(s);
    samples_queued++;
  endfunction

  task automatic write_reg(fpd_pkg::cfg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      fpd_pkg::CFG_LAUNCH_LIMIT: lim_launch = val[14:0];
      fpd_pkg::CFG_APOGEE_LIMIT: lim_apogee = val;
      fpd_pkg::CFG_LANDING_BAND: lim_band   = val[14:0];
      fpd_pkg::CFG_COUNT_LIMIT:  lim_count  = val;
      default: ;
    endcase
  endtask

  task automatic program_limits(int launch, int apogee, int band, int count);
    write_reg(fpd_pkg::CFG_LAUNCH_LIMIT, 16'(launch));
    write_reg(fpd_pkg::CFG_APOGEE_LIMIT, 16'(apogee));
    write_reg(fpd_pkg::CFG_LANDING_BAND, 16'(band));
    write_reg(fpd_pkg::CFG_COUNT_LIMIT, 16'(count));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (samples_taken != samples_queued || due_reports.size() != 0);
  endtask

  // driver: hold a beat until taken, then advance or idle
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (!no_idle && $urandom_range(11, 0) == 0) begin
        send_gap = $urandom_range(7, 0);
        in_valid <= 1'b0;
      end else if (samples_to_send.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= samples_to_send.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_gap > 0) begin
      stall_gap--;
      out_stall <= 1'b1;
    end else if (!no_idle && $urandom_range(9, 0) == 0) begin
      stall_gap = $urandom_range(7, 0);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: check result beats, predict on input beats, watch for a hang
  always @(posedge clk) begin
    fpd_pkg::out_t want;
    logic out_taken;
    in_taken  = 1'b0;
    out_taken = rst_n && out_valid && !out_stall;
    if (out_taken) begin
      if (due_reports.size() == 0) begin
        mismatches++;
        $display("%0t: report expected none, got %h", $time, out_data);
      end else begin
        want = due_reports.pop_front();
        compare_field("flight_stage", want.flight_stage, out_data.flight_stage);
        compare_field("buzzer_mode", want.buzzer_mode, out_data.buzzer_mode);
        compare_field("pyro_fire", want.pyro_fire, out_data.pyro_fire);
        compare_field("launch_seen", want.launch_seen, out_data.launch_seen);
        compare_field("apogee_seen", want.apogee_seen, out_data.apogee_seen);
        compare_field("landing_seen", want.landing_seen, out_data.landing_seen);
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      in_taken = 1'b1;
      due_reports.push_back(advance_flight(in_data));
      samples_taken++;
    end
    quiet_cycles = (in_taken || out_taken) ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int alim;
    int band;
    int n;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    queue_sample(make_sample(0, 0, 0, 0));
    queue_sample(make_sample(0, 5120, 0, -32768));
    queue_sample(make_sample(-5120, 0, 0, 32767));
    queue_sample(make_sample(3620, 3620, 0, -102));
    queue_sample(make_sample(-2956, -2956, -2956, 20));
    wait_drained();

    program_limits(32767, -32768, 0, 0);
    repeat (120) queue_sample(rand_sample(18000, -32768, 32767));
    queue_sample(make_sample(32767, 0, 0, 0));
    queue_sample(make_sample(0, 32767, 0, 0));
    queue_sample(make_sample(-32768, 0, 0, -32768));
    repeat (4) queue_sample(rand_sample(32768, -32768, -32768));
    wait_drained();

    alim = -int'($urandom_range(2000, 1));
    program_limits(0, alim, 20, 65534);
    queue_sample(make_sample(1, -1, 0, alim));
    queue_sample(make_sample(-1, 1, 0, alim - 1));
    repeat (150) begin
      if ($urandom_range(1, 0) != 0) queue_sample(rand_sample(32768, -32768, alim - 1));
      else queue_sample(rand_sample(32768, alim, 32767));
    end
    wait_drained();

    program_limits(0, -32768, 0, 65534);
    queue_sample(make_sample(0, 0, 0, 0));
    queue_sample(make_sample(0, 0, 0, -1));
    queue_sample(make_sample(0, 0, 0, 1));
    repeat (60) queue_sample(rand_sample(32768, -32768, 32767));
    wait_drained();

    program_limits(32767, 0, 32767, 65534);
    queue_sample(make_sample(0, 0, 0, -32768));
    queue_sample(make_sample(0, 0, 0, -32767));
    queue_sample(make_sample(0, 0, 0, 32767));
    queue_sample(make_sample(0, 0, 0, 32766));
    queue_sample(make_sample(0, 0, 0, -32766));
    queue_sample(make_sample(0, 0, 0, 0));
    repeat (110) queue_sample(rand_sample(32768, -32768, 32767));
    wait_drained();

    band = $urandom_range(3000, 1);
    program_limits(5120, -102, band, int'(fl_count) + 40);
    queue_sample(make_sample(0, 0, 0, band));
    queue_sample(make_sample(0, 0, 0, -band));
    queue_sample(make_sample(0, 0, 0, band - 1));
    repeat (180) begin
      n = $urandom_range(3, 0);
      if (n < 2) queue_sample(rand_sample(32768, 1 - band, band - 1));
      else if (n == 2) queue_sample(rand_sample(32768, band, 32767));
      else queue_sample(rand_sample(32768, -32768, -band));
    end
    wait_drained();

    no_idle = 1'b1;
    program_limits(32767, 0, 20, 0);
    repeat (60) queue_sample(rand_sample(32768, -32768, 32767));
    wait_drained();

    repeat (SettleCycles) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
